### rtl/smavg_pkg.sv
// Shared constants and types for the scaled moving average block.
// Used by the top level, the delay line RAM instance and the checker.
`default_nettype none

package smavg_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W    = $clog2(MAX_WINDOW);
    localparam int FILL_W    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int LEN_W     = 9;
    localparam int COEF_W    = 24;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 24;
    localparam int IDX_W     = 2;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = SUM_W + COEF_W;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    localparam int ACC_W     = SHIFT_W + 1;

    localparam logic [LEN_W-1:0]         WINDOW_RST = LEN_W'(1);
    localparam logic signed [COEF_W-1:0] GAIN_RST   = COEF_W'(65536);
    localparam logic signed [OUT_W-1:0]  OFFSET_RST = '0;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_LEN = 2'd0,
        REG_GAIN       = 2'd1,
        REG_OFFSET     = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

### rtl/smavg_ram.sv
// Generic single write port, single read port RAM with registered read.
// Read-first on a same-address write. No package dependency.
`default_nettype none

module smavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

### rtl/scaled_moving_average.sv
// Scaled boxcar moving average: delay line RAM, exact running sum, gain and offset.
// Depends on smavg_pkg and smavg_ram.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_sample, i_new_vector
//   result    out        o_valid / i_stall    o_average
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One sample per clock while o_stall is low; a sample that completes its window gives a result
// through the steps delay line read, running sum, multiply, then offset and saturation into o_average.
// The throughput is set by the running sum loop through r_sum.
// Synchronous reset empties the pipeline, clears sum, fill count and pointer, and loads config defaults.
// Each stage holds under a downstream stall and fills any bubble ahead of it.
`default_nettype none

module scaled_moving_average (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [smavg_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                   i_new_vector,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [smavg_pkg::OUT_W-1:0]          o_average,
    input  wire logic                                   i_cfg_we,
    input  wire logic [smavg_pkg::IDX_W-1:0]            i_cfg_index,
    input  wire logic [smavg_pkg::CFG_W-1:0]            i_cfg_data
);

    // configuration
    logic [smavg_pkg::LEN_W-1:0]         r_len;
    logic signed [smavg_pkg::COEF_W-1:0] r_gain;
    logic signed [smavg_pkg::OUT_W-1:0]  r_offset;

    // window state
    logic [smavg_pkg::FILL_W-1:0]       r_fill, n_fill;
    logic [smavg_pkg::ADDR_W-1:0]       r_wp, n_wp;
    logic signed [smavg_pkg::SUM_W-1:0] r_sum, n_sum;

    // pipeline
    logic                                      r_s1_v, r_s2_v, r_s3_v;
    logic signed [smavg_pkg::SAMPLE_BITS-1:0]  r_s1_sample;
    logic                                      r_s1_clear, r_s1_sub, r_s1_emit;
    logic signed [smavg_pkg::SUM_W-1:0]        r_s2_sum;
    logic signed [smavg_pkg::PROD_W-1:0]       r_s3_prod;
    logic signed [smavg_pkg::OUT_W-1:0]        n_average;

    logic                                      take1, take2, take3, out_free, accept;
    logic                                      len_write;
    logic [smavg_pkg::FILL_W-1:0]              w_eff, fill_base, wp_ext;
    logic [smavg_pkg::ADDR_W-1:0]              rd_addr;
    logic                                      sub_now, emit_now;
    logic [smavg_pkg::SAMPLE_BITS-1:0]         rd_data;
    logic signed [smavg_pkg::SUM_W-1:0]        sum_base, old_ext;
    logic signed [smavg_pkg::PROD_W-1:0]       n_prod;
    logic signed [smavg_pkg::SHIFT_W-1:0]      shifted;
    logic signed [smavg_pkg::ACC_W-1:0]        acc;

    // stage advance, back to front
    assign out_free = !o_valid || !i_stall;
    assign take3    = !r_s3_v || out_free;
    assign take2    = !r_s2_v || take3;
    assign take1    = !r_s1_v || take2;
    assign o_stall  = !take1;
    assign accept   = i_valid && take1;

    // a window length write restarts the window
    assign len_write = i_cfg_we && (i_cfg_index == smavg_pkg::REG_WINDOW_LEN);

    // zero-length window acts as one, oversize clamps to the delay line depth
    always_comb begin
        if (r_len == '0) begin
            w_eff = smavg_pkg::FILL_W'(1);
        end else if (32'(r_len) > smavg_pkg::MAX_WINDOW) begin
            w_eff = smavg_pkg::FILL_W'(smavg_pkg::MAX_WINDOW);
        end else begin
            w_eff = smavg_pkg::FILL_W'(r_len);
        end
    end

    // slot of the sample that leaves the window, wrapping at the depth
    always_comb begin
        wp_ext = smavg_pkg::FILL_W'(r_wp);
        if (wp_ext >= w_eff) begin
            rd_addr = smavg_pkg::ADDR_W'(wp_ext - w_eff);
        end else begin
            rd_addr = smavg_pkg::ADDR_W'(wp_ext + smavg_pkg::FILL_W'(smavg_pkg::MAX_WINDOW)
                                         - w_eff);
        end
    end

    // fill count and pointer advance at the input transfer
    always_comb begin
        fill_base = i_new_vector ? '0 : r_fill;
        sub_now   = fill_base >= w_eff;
        n_fill    = sub_now ? w_eff : fill_base + smavg_pkg::FILL_W'(1);
        emit_now  = n_fill >= w_eff;
        if (32'(r_wp) == smavg_pkg::MAX_WINDOW - 1) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + smavg_pkg::ADDR_W'(1);
        end
    end

    smavg_ram #(
        .WIDTH(smavg_pkg::SAMPLE_BITS),
        .DEPTH(smavg_pkg::MAX_WINDOW)
    ) u_delay (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(r_wp),
        .i_wdata(i_sample),
        .i_re   (accept),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // running sum: add the new sample, drop the one that left the window
    always_comb begin
        sum_base = r_s1_clear ? '0 : r_sum;
        old_ext  = r_s1_sub ? smavg_pkg::SUM_W'($signed(rd_data)) : '0;
        n_sum    = sum_base + smavg_pkg::SUM_W'(r_s1_sample) - old_ext;
    end

    assign n_prod = r_s2_sum * r_gain;

    // floor shift, offset, saturate
    always_comb begin
        shifted = smavg_pkg::SHIFT_W'(r_s3_prod >>> smavg_pkg::FRAC_BITS);
        acc     = smavg_pkg::ACC_W'(shifted) + smavg_pkg::ACC_W'(r_offset);
        if (acc > smavg_pkg::ACC_W'(smavg_pkg::OUT_MAX)) begin
            n_average = smavg_pkg::OUT_MAX;
        end else if (acc < smavg_pkg::ACC_W'(smavg_pkg::OUT_MIN)) begin
            n_average = smavg_pkg::OUT_MIN;
        end else begin
            n_average = smavg_pkg::OUT_W'(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= smavg_pkg::WINDOW_RST;
            r_gain   <= smavg_pkg::GAIN_RST;
            r_offset <= smavg_pkg::OFFSET_RST;
            r_fill   <= '0;
            r_wp     <= '0;
            r_sum    <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (len_write) begin
                r_fill <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
            if (accept) begin
                r_wp <= n_wp;
            end
            if (len_write) begin
                r_sum <= '0;
            end else if (r_s1_v && take2) begin
                r_sum <= n_sum;
            end
            if (take1) begin
                r_s1_v <= i_valid;
            end
            if (take2) begin
                // samples that only fill the window end here
                r_s2_v <= r_s1_v && r_s1_emit;
            end
            if (take3) begin
                r_s3_v <= r_s2_v;
            end
            if (out_free) begin
                o_valid <= r_s3_v;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    smavg_pkg::REG_WINDOW_LEN: r_len <= i_cfg_data[smavg_pkg::LEN_W-1:0];
                    smavg_pkg::REG_GAIN:   r_gain   <= $signed(i_cfg_data[smavg_pkg::COEF_W-1:0]);
                    smavg_pkg::REG_OFFSET: r_offset <= $signed(i_cfg_data[smavg_pkg::OUT_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= i_sample;
            r_s1_clear  <= i_new_vector;
            r_s1_sub    <= sub_now;
            r_s1_emit   <= emit_now;
        end
        if (r_s1_v && take2) begin
            r_s2_sum <= n_sum;
        end
        if (take3) begin
            r_s3_prod <= n_prod;
        end
        if (out_free && r_s3_v) begin
            o_average <= n_average;
        end
    end

endmodule

`default_nettype wire

### rtl/smavg_chk.sv
// Port-level checker for scaled_moving_average, attached with a bind.
// Depends on smavg_pkg for widths.
`default_nettype none

module smavg_chk (
    input wire logic                                     i_clk,
    input wire logic                                     i_rst_n,
    input wire logic                                     i_valid,
    input wire logic                                     o_stall,
    input wire logic signed [smavg_pkg::SAMPLE_BITS-1:0] i_sample,
    input wire logic                                     i_new_vector,
    input wire logic                                     o_valid,
    input wire logic                                     i_stall,
    input wire logic signed [smavg_pkg::OUT_W-1:0]       o_average
);

    // reset leaves the pipeline empty and open
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_average))
        else $error("stalled result changed");

    // a stalled input transfer holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_sample) && $stable(i_new_vector))
        else $error("stalled input changed");

    // with no result waiting, every stage can advance
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register empty");

    // input can only be stalled when a result waits under a stall
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without downstream stall");

endmodule

bind scaled_moving_average smavg_chk u_smavg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_sample    (i_sample),
    .i_new_vector(i_new_vector),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_average   (o_average)
);

`default_nettype wire

### test/tb_scaled_moving_average.sv
// Self-checking testbench for scaled_moving_average: directed and random sample streams.
// Predicts each average from its own window model. Depends on smavg_pkg and the block RTL.
`default_nettype none

module tb_scaled_moving_average;

    localparam int SETTLE_CYCLES = 32;
    localparam logic [smavg_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [smavg_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
        {1'b0, {(smavg_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [smavg_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(smavg_pkg::SAMPLE_BITS-1){1'b0}}};

    typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} t_stall_pattern;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n = 1'b0;
    logic                                     i_valid = 1'b0;
    logic                                     o_stall;
    logic signed [smavg_pkg::SAMPLE_BITS-1:0] i_sample = '0;
    logic                                     i_new_vector = 1'b0;
    logic                                     o_valid;
    logic                                     i_stall = 1'b0;
    logic signed [smavg_pkg::OUT_W-1:0]       o_average;
    logic                                     i_cfg_we = 1'b0;
    logic [smavg_pkg::IDX_W-1:0]              i_cfg_index = '0;
    logic [smavg_pkg::CFG_W-1:0]              i_cfg_data = '0;

    // window model
    logic signed [smavg_pkg::SAMPLE_BITS-1:0] tap_history [smavg_pkg::MAX_WINDOW];
    longint                                   window_total = 0;
    int                                       fill_level = 0;
    logic [smavg_pkg::ADDR_W-1:0]             tap_ptr = '0;
    logic [smavg_pkg::LEN_W-1:0]              cur_window = smavg_pkg::WINDOW_RST;
    logic signed [smavg_pkg::COEF_W-1:0]      cur_gain = smavg_pkg::GAIN_RST;
    logic signed [smavg_pkg::OUT_W-1:0]       cur_offset = smavg_pkg::OFFSET_RST;

    logic signed [smavg_pkg::OUT_W-1:0]       expected_averages [$];
    logic signed [smavg_pkg::OUT_W-1:0]       oldest_average;
    int                                       mismatches = 0;
    int                                       burst_left = 0;

    t_stall_pattern                           stall_pattern = STALL_NONE;
    int                                       stall_span = 0;
    int                                       stall_tick = 0;

    scaled_moving_average u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_new_vector (i_new_vector),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_average    (o_average),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_average(input logic signed [smavg_pkg::SAMPLE_BITS-1:0] s,
                                            input logic nv);
        int     w;
        longint scaled;
        w = (cur_window == 0) ? 1 :
            (cur_window > smavg_pkg::MAX_WINDOW) ? smavg_pkg::MAX_WINDOW : int'(cur_window);
        if (nv) begin
            fill_level = 0;
            window_total = 0;
        end
        window_total += s;
        if (fill_level >= w) begin
            // drop the sample that falls out of the window
            window_total -= tap_history[(int'(tap_ptr) + smavg_pkg::MAX_WINDOW - w)
                                        % smavg_pkg::MAX_WINDOW];
            fill_level = w;
        end else begin
            fill_level++;
        end
        tap_history[tap_ptr] = s;
        tap_ptr++;
        if (fill_level < w) return;
        scaled = ((window_total * cur_gain) >>> smavg_pkg::FRAC_BITS) + cur_offset;
        if (scaled > longint'(smavg_pkg::OUT_MAX)) scaled = longint'(smavg_pkg::OUT_MAX);
        if (scaled < longint'(smavg_pkg::OUT_MIN)) scaled = longint'(smavg_pkg::OUT_MIN);
        expected_averages.push_back(scaled[smavg_pkg::OUT_W-1:0]);
    endfunction

    function automatic logic signed [smavg_pkg::SAMPLE_BITS-1:0] random_sample(
        input int extreme_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < extreme_pct / 2) return SAMPLE_MAX;
        if (pick < extreme_pct) return SAMPLE_MIN;
        return smavg_pkg::SAMPLE_BITS'($urandom);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_averages.size() == 0) begin
                $error("average: expected none, actual %0d", o_average);
                mismatches++;
            end else begin
                oldest_average = expected_averages.pop_front();
                if (o_average !== oldest_average) begin
                    $error("average: expected %0d, actual %0d", oldest_average, o_average);
                    mismatches++;
                end
            end
        end
    end

    // receiver back-pressure: switch pattern every so often
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_pattern = t_stall_pattern'($urandom_range(0, 3));
            stall_span = $urandom_range(16, 160);
        end
        stall_span--;
        stall_tick++;
        case (stall_pattern)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_COIN:     i_stall <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: i_stall <= ((stall_tick % 7) < 3);
            default:        i_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input logic signed [smavg_pkg::SAMPLE_BITS-1:0] s,
                               input logic nv);
        if (burst_left == 0) begin
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_sample <= s;
        i_new_vector <= nv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_average(s, nv);
    endtask

    // hold the sender until every average is back and the pipeline is empty
    task automatic drain_results();
        idle_cycles(1);
        while (expected_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [smavg_pkg::IDX_W-1:0] idx,
                             input logic [smavg_pkg::CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            smavg_pkg::REG_WINDOW_LEN: begin
                cur_window = data[smavg_pkg::LEN_W-1:0];
                fill_level = 0;
                window_total = 0;
            end
            smavg_pkg::REG_GAIN:   cur_gain = data;
            smavg_pkg::REG_OFFSET: cur_offset = data;
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sh5A5A, 1'b1);
    endtask

    task automatic test_window_length_codes();
        drain_results();
        // zero length behaves as a window of one
        write_reg(smavg_pkg::REG_WINDOW_LEN, '0);
        send_sample(16'sd1234, 1'b0);
        send_sample(-16'sd1234, 1'b0);
        drain_results();
        // only the low nine bits select the length
        write_reg(smavg_pkg::REG_WINDOW_LEN, 24'hABC003);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd100, 1'b1);
        send_sample(16'sd200, 1'b0);
        send_sample(16'sd300, 1'b0);
        send_sample(16'sd400, 1'b0);
    endtask

    task automatic test_saturation_and_unused_index();
        drain_results();
        write_reg(smavg_pkg::REG_WINDOW_LEN, 24'd2);
        write_reg(smavg_pkg::REG_GAIN, 24'h7FFFFF);
        write_reg(smavg_pkg::REG_OFFSET, 24'h7FFFFF);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        drain_results();
        write_reg(smavg_pkg::REG_GAIN, 24'h800000);
        write_reg(smavg_pkg::REG_OFFSET, 24'h800000);
        send_sample(SAMPLE_MAX, 1'b0);
        drain_results();
        write_reg(REG_UNUSED, 24'hFFFFFF);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample('0, 1'b0);
    endtask

    task automatic test_random_short_windows();
        int                          w;
        int                          n;
        int                          nv_odds;
        logic [smavg_pkg::CFG_W-1:0] gain_word;
        logic [smavg_pkg::CFG_W-1:0] offset_word;
        for (int phase = 0; phase < 12; phase++) begin
            drain_results();
            case (phase)
                0:       w = 0;
                1:       w = 1;
                default: w = $urandom_range(1, 16);
            endcase
            write_reg(smavg_pkg::REG_WINDOW_LEN, {15'($urandom), 9'(w)});
            case ($urandom_range(0, 4))
                0:       gain_word = 24'h7FFFFF;
                1:       gain_word = 24'h800000;
                2:       gain_word = 24'($urandom);
                default: gain_word = 24'(65536 / ((w == 0) ? 1 : w));
            endcase
            case ($urandom_range(0, 4))
                0:       offset_word = 24'h7FFFFF;
                1:       offset_word = 24'h800000;
                2:       offset_word = 24'($urandom);
                3:       offset_word = 24'(int'($urandom_range(0, 2000)) - 1000);
                default: offset_word = '0;
            endcase
            write_reg(smavg_pkg::REG_GAIN, gain_word);
            write_reg(smavg_pkg::REG_OFFSET, offset_word);
            // every fourth phase breaks vectors often, the rest let windows fill
            nv_odds = (phase % 4 == 3) ? 3 : 4 * (w + 4);
            n = $urandom_range(28, 38);
            for (int i = 0; i < n; i++) begin
                if (phase % 3 == 0 && i == n / 2) drain_results();
                send_sample(random_sample(15), $urandom_range(1, nv_odds) == 1);
            end
        end
    endtask

    task automatic test_full_windows();
        drain_results();
        write_reg(smavg_pkg::REG_WINDOW_LEN, 24'd256);
        write_reg(smavg_pkg::REG_GAIN, 24'd256);
        write_reg(smavg_pkg::REG_OFFSET, 24'(int'($urandom_range(0, 2000)) - 1000));
        repeat (265) begin
            send_sample(($urandom_range(0, 9) < 7) ? SAMPLE_MAX : random_sample(10), 1'b0);
        end
        drain_results();
        // length beyond the delay line clamps to its depth
        write_reg(smavg_pkg::REG_WINDOW_LEN, 24'h0001FF);
        write_reg(smavg_pkg::REG_GAIN, 24'h7FFFFF);
        write_reg(smavg_pkg::REG_OFFSET, '0);
        repeat (265) begin
            send_sample(($urandom_range(0, 9) < 8) ? SAMPLE_MIN : random_sample(10), 1'b0);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_window_length_codes();
        test_saturation_and_unused_index();
        test_random_short_windows();
        test_full_windows();
        drain_results();
        if (mismatches == 0) begin
            $display("scaled_moving_average regression: pass");
        end else begin
            $display("scaled_moving_average regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("scaled_moving_average regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
